[design/vfpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfpa_pkg: shared definitions for the vertical force pi admittance core
// widths, reset values, register codes and the fixed-point helpers used by
// the sequencer and the digit-serial multiplier
// ----------------------------------------------------------------------------
package vfpa_pkg;

	localparam int TIME_W     = 48;                 // sim_time, last_time, dt
	localparam int DATA_W     = 32;                 // registers, fields, outputs
	localparam int ERR_W      = 34;                 // force error, Q18.16
	localparam int INTEG_W    = 48;                 // error integral, Q32.16
	localparam int FRAC_W     = 16;                 // fraction bits of Q.16
	localparam int MUL_A_W    = 48;                 // multiplicand magnitude
	localparam int MUL_B_W    = 36;                 // multiplier magnitude, whole digits
	localparam int DIGIT_W    = 4;                  // bits retired per cycle
	localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;  // digits per product
	localparam int MUL_CNT_W  = $clog2(MUL_DIGITS + 1);
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int RND_W      = PROD_W - FRAC_W + 1;
	localparam int TERM_W     = 52;                 // one rounded term, +-2^50
	localparam int SUM_W      = 53;                 // sum of two terms
	localparam int CFG_IDX_W  = 2;

	// rounded product magnitudes clamp here
	localparam logic [RND_W-1:0] TERM_LIMIT = {{(RND_W-51){1'b0}}, 1'b1, 50'd0};

	localparam logic [DATA_W-1:0] TARGET_RST = 32'd655360;
	localparam logic [DATA_W-1:0] PROP_RST   = 32'd6554;
	localparam logic [DATA_W-1:0] IGAIN_RST  = 32'd3277;
	localparam logic [DATA_W-1:0] LAT_RST    = 32'd6554;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 2'd0,
		REG_PROP   = 2'd1,
		REG_IGAIN  = 2'd2,
		REG_LAT    = 2'd3
	} cfg_reg_t;

	// start of one product, with its operand magnitudes
	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	// magnitude of a 48-bit two's complement value, the most negative fits
	function automatic logic [MUL_A_W-1:0] mag48(input logic [INTEG_W-1:0] v);
		return v[INTEG_W-1] ? (~v + 1'b1) : v;
	endfunction

	// clamp a term sum to the 32-bit signed range
	function automatic logic [DATA_W-1:0] sat_data(input logic [SUM_W-1:0] v);
		logic [SUM_W-DATA_W:0] hi;
		hi = v[SUM_W-1:DATA_W-1];
		if ((&hi) || !(|hi))
			return v[DATA_W-1:0];
		else if (v[SUM_W-1])
			return {1'b1, {(DATA_W-1){1'b0}}};
		else
			return {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

	// clamp a term sum to the 48-bit signed integral range
	function automatic logic [INTEG_W-1:0] sat_integ(input logic [SUM_W-1:0] v);
		logic [SUM_W-INTEG_W:0] hi;
		hi = v[SUM_W-1:INTEG_W-1];
		if ((&hi) || !(|hi))
			return v[INTEG_W-1:0];
		else if (v[SUM_W-1])
			return {1'b1, {(INTEG_W-1){1'b0}}};
		else
			return {1'b0, {(INTEG_W-1){1'b1}}};
	endfunction

endpackage
`default_nettype wire

[design/vfpa_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfpa_mul: digit-serial unsigned multiplier
// retires one 4-bit digit of the multiplier per cycle, right-shifting the
// partial product; the full product is ready the cycle done is high
// ----------------------------------------------------------------------------
module vfpa_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire vfpa_pkg::mul_req_t          req,
	output logic                             done,
	output logic [vfpa_pkg::PROD_W-1:0]      prod
);

	localparam int AW = vfpa_pkg::MUL_A_W;
	localparam int BW = vfpa_pkg::MUL_B_W;
	localparam int DW = vfpa_pkg::DIGIT_W;
	localparam int PW = vfpa_pkg::PROD_W;
	localparam int CW = vfpa_pkg::MUL_CNT_W;

	logic [AW-1:0]    a_q;
	logic [PW-1:0]    acc_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [AW+DW-1:0] part;
	logic [AW+DW-1:0] hi_sum;

	// multiplicand times the lowest digit, added into the upper half
	assign part   = {{DW{1'b0}}, a_q} * {{AW{1'b0}}, acc_q[DW-1:0]};
	assign hi_sum = {{DW{1'b0}}, acc_q[PW-1:BW]} + part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(vfpa_pkg::MUL_DIGITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			acc_q <= {{AW{1'b0}}, req.b};
		end else if (busy_q) begin
			acc_q <= {hi_sum, acc_q[BW-1:DW]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

[design/vertical_force_pi_admittance_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vertical_force_pi_admittance_core: pi force controller on Q16.16 data
// turns a time stamp, a vertical force and a lateral position into vertical
// and lateral velocity commands, keeping a saturated error integral
// ----------------------------------------------------------------------------
// Each input word goes through the prep, multiply, round and apply states
// before its result is loaded in the output register, and the next word
// can be taken in the cycle after that, so only one word is in flight at a
// time. Four Q16.16 products are formed one after another on a single
// digit-serial multiplier that retires four bits per cycle: dt*error,
// prop_gain*error, integ_gain*integral and -lateral_gain*handle_x, each
// followed by rounding and update; the third depends on the integral the
// first one leaves. A finished result sits in the output register until
// taken, and the block only waits for it when a second result is ready
// before the first has gone. Products round to nearest with ties away from
// zero, the integral clamps to 48-bit signed and both outputs clamp to 32-bit
// signed. The first word after reset gets a zero time step. Configuration
// is always ready; write it while no word is in flight.
// ----------------------------------------------------------------------------
module vertical_force_pi_admittance_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [vfpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [vfpa_pkg::DATA_W-1:0]        cfg_data,
	// input words
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [vfpa_pkg::TIME_W-1:0]        sim_time,
	input  wire logic signed [vfpa_pkg::DATA_W-1:0] force_z,
	input  wire logic signed [vfpa_pkg::DATA_W-1:0] handle_x,
	// result words
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [vfpa_pkg::DATA_W-1:0]      vel_x,
	output logic signed [vfpa_pkg::DATA_W-1:0]      vel_z
);

	localparam int DW  = vfpa_pkg::DATA_W;
	localparam int TW  = vfpa_pkg::TIME_W;
	localparam int EW  = vfpa_pkg::ERR_W;
	localparam int IW  = vfpa_pkg::INTEG_W;
	localparam int AW  = vfpa_pkg::MUL_A_W;
	localparam int BW  = vfpa_pkg::MUL_B_W;
	localparam int PW  = vfpa_pkg::PROD_W;
	localparam int FW  = vfpa_pkg::FRAC_W;
	localparam int RW  = vfpa_pkg::RND_W;
	localparam int TMW = vfpa_pkg::TERM_W;
	localparam int SW  = vfpa_pkg::SUM_W;

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PREP  = 6'b000010,
		S_MUL   = 6'b000100,
		S_ROUND = 6'b001000,
		S_APPLY = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	// which product is on the multiplier
	typedef enum logic [1:0] {
		OP_INTEG = 2'd0,   // dt * error, into the integral
		OP_PROP  = 2'd1,   // prop_gain * error
		OP_IGAIN = 2'd2,   // integ_gain * integral
		OP_LAT   = 2'd3    // -lateral_gain * handle_x
	} op_t;

	state_t state_q;
	op_t    op_q;
	op_t    sel_op;

	// configuration registers
	logic [DW-1:0] target_q;
	logic [DW-1:0] prop_q;
	logic [DW-1:0] igain_q;
	logic [DW-1:0] lat_q;

	// controller state
	logic          started_q;
	logic [TW-1:0] last_time_q;
	logic [IW-1:0] integ_q;

	// per-word working registers
	logic [EW-1:0]  err_q;
	logic [TW-1:0]  dt_q;
	logic [DW-1:0]  hx_q;
	logic           neg_q;
	logic [TMW-1:0] term_q;
	logic [SW-1:0]  vz_q;

	// output register
	logic          out_valid_q;
	logic [DW-1:0] vel_x_q;
	logic [DW-1:0] vel_z_q;

	logic           accept;
	logic [EW-1:0]  err_c;
	logic [AW-1:0]  dt_mag;
	logic [AW-1:0]  err_mag;
	logic [AW-1:0]  integ_mag;
	logic [AW-1:0]  prop_mag;
	logic [AW-1:0]  igain_mag;
	logic [AW-1:0]  lat_mag;
	logic [AW-1:0]  hx_mag;
	logic           neg_c;
	logic [RW-1:0]  rnd_c;
	logic [RW-1:0]  clamp_c;
	logic [TMW-1:0] term_c;
	logic [SW-1:0]  term_ext;

	vfpa_pkg::mul_req_t mul_req;
	logic               mul_done;
	logic [PW-1:0]      mul_prod;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// error = -target - force, exact in 34 bits
	assign err_c = {EW{1'b0}} - {{(EW-DW){target_q[DW-1]}}, target_q}
		- {{(EW-DW){force_z[DW-1]}}, force_z};

	// operand magnitudes
	assign dt_mag    = vfpa_pkg::mag48(dt_q);
	assign err_mag   = vfpa_pkg::mag48({{(IW-EW){err_q[EW-1]}}, err_q});
	assign integ_mag = vfpa_pkg::mag48(integ_q);
	assign prop_mag  = vfpa_pkg::mag48({{(IW-DW){prop_q[DW-1]}}, prop_q});
	assign igain_mag = vfpa_pkg::mag48({{(IW-DW){igain_q[DW-1]}}, igain_q});
	assign lat_mag   = vfpa_pkg::mag48({{(IW-DW){lat_q[DW-1]}}, lat_q});
	assign hx_mag    = vfpa_pkg::mag48({{(IW-DW){hx_q[DW-1]}}, hx_q});

	// on apply the next product is launched, otherwise the current one
	assign sel_op = (state_q == S_APPLY) ? op_t'(op_q + 2'd1) : op_q;

	always_comb begin
		mul_req.start = (state_q == S_PREP) || ((state_q == S_APPLY) && (op_q != OP_LAT));
		unique case (sel_op)
			OP_INTEG: begin
				mul_req.a = dt_mag;
				mul_req.b = err_mag[BW-1:0];
				neg_c     = dt_q[TW-1] ^ err_q[EW-1];
			end
			OP_PROP: begin
				mul_req.a = err_mag;
				mul_req.b = prop_mag[BW-1:0];
				neg_c     = prop_q[DW-1] ^ err_q[EW-1];
			end
			OP_IGAIN: begin
				mul_req.a = integ_mag;
				mul_req.b = igain_mag[BW-1:0];
				neg_c     = igain_q[DW-1] ^ integ_q[IW-1];
			end
			OP_LAT: begin
				// the gain enters negated: its sign flips unless it is zero
				mul_req.a = hx_mag;
				mul_req.b = lat_mag[BW-1:0];
				neg_c     = (~lat_q[DW-1] & (|lat_q)) ^ hx_q[DW-1];
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
				neg_c     = 1'b0;
			end
		endcase
	end

	vfpa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// drop 16 fraction bits, ties away from zero on the magnitude, then clamp
	assign rnd_c   = {1'b0, mul_prod[PW-1:FW]} + {{(RW-1){1'b0}}, mul_prod[FW-1]};
	assign clamp_c = (rnd_c > vfpa_pkg::TERM_LIMIT) ? vfpa_pkg::TERM_LIMIT : rnd_c;
	assign term_c  = neg_q ? (~clamp_c[TMW-1:0] + 1'b1) : clamp_c[TMW-1:0];

	assign term_ext = {{(SW-TMW){term_q[TMW-1]}}, term_q};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= vfpa_pkg::TARGET_RST;
			prop_q   <= vfpa_pkg::PROP_RST;
			igain_q  <= vfpa_pkg::IGAIN_RST;
			lat_q    <= vfpa_pkg::LAT_RST;
		end else if (cfg_valid) begin
			unique case (vfpa_pkg::cfg_reg_t'(cfg_index))
				vfpa_pkg::REG_TARGET: target_q <= cfg_data;
				vfpa_pkg::REG_PROP:   prop_q   <= cfg_data;
				vfpa_pkg::REG_IGAIN:  igain_q  <= cfg_data;
				vfpa_pkg::REG_LAT:    lat_q    <= cfg_data;
				default:              ;
			endcase
		end
	end

	// sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_INTEG;
			started_q   <= 1'b0;
			last_time_q <= '0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded at the end of a word, emptied when taken
			if ((state_q == S_OUT) && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						// record the time; the first word after reset gets a zero time step
						started_q   <= 1'b1;
						last_time_q <= sim_time;
						op_q        <= OP_INTEG;
						state_q     <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mul_done)
						state_q <= S_ROUND;
				end
				S_ROUND: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					unique case (op_q)
						OP_INTEG: integ_q <= vfpa_pkg::sat_integ(
							{{(SW-IW){integ_q[IW-1]}}, integ_q} + term_ext);
						default:  ;
					endcase
					if (op_q == OP_LAT) begin
						state_q <= S_OUT;
					end else begin
						op_q    <= sel_op;
						state_q <= S_MUL;
					end
				end
				S_OUT: begin
					// hold here only while an untaken result blocks the register
					if (!out_valid_q || out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working data, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= err_c;
			dt_q  <= started_q ? (sim_time - last_time_q) : {TW{1'b0}};
			hx_q  <= handle_x;
		end
		if (mul_req.start)
			neg_q <= neg_c;
		if (state_q == S_ROUND)
			term_q <= term_c;
		if (state_q == S_APPLY) begin
			unique case (op_q)
				OP_PROP:  vz_q <= term_ext;
				OP_IGAIN: vz_q <= vz_q + term_ext;
				default:  ;
			endcase
		end
		if ((state_q == S_OUT) && (!out_valid_q || out_ready)) begin
			vel_x_q <= vfpa_pkg::sat_data(term_ext);
			vel_z_q <= vfpa_pkg::sat_data(vz_q);
		end
	end

	assign out_valid = out_valid_q;
	assign vel_x     = vel_x_q;
	assign vel_z     = vel_z_q;

endmodule
`default_nettype wire

[design/vfpa_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfpa_checker: port-level checks for the vertical force pi admittance core
// watches the handshakes over time and is bound onto the top level
// ----------------------------------------------------------------------------
module vfpa_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cfg_ready,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [vfpa_pkg::DATA_W-1:0]   vel_x,
	input wire logic [vfpa_pkg::DATA_W-1:0]   vel_z
);

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vel_x) && $stable(vel_z))
		else $error("result word changed while stalled");

	// one word in flight: busy straight after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while a word is in flight");

	// a new result only appears at the end of the work on a word
	a_result_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

	// going ready again means the result has been loaded
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("ready again without a result word");

	// configuration is never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port stalled");

endmodule

bind vertical_force_pi_admittance_core vfpa_checker u_vfpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.vel_x     (vel_x),
	.vel_z     (vel_z)
);
`default_nettype wire
